// ===== hdl/dual_encoding_pattern_scanner_defines.svh =====
// Assertion macros shared by the pattern scanner RTL.
// Included by each module that carries concurrent checks; no other dependencies.
`ifndef DUAL_ENCODING_PATTERN_SCANNER_DEFINES_SVH
`define DUAL_ENCODING_PATTERN_SCANNER_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define DESC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define DESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `DESC_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== hdl/desc_pkg.sv =====
// Shared constants and types for the dual encoding pattern scanner.
// No dependencies; compiled first.
`default_nettype none

package desc_pkg;

  localparam int MAX_PATTERN_DEF = 16;   // default and upper bound of pattern bytes
  localparam int ADDR_W          = 64;
  localparam int OFF_W           = 32;   // region offset wraps at 2^32
  localparam int REG_W           = 64;
  localparam int PAT_LEN_W       = 5;
  localparam int PAT_BYTES_W     = 128;  // both pattern registers side by side
  localparam int CFG_IDX_W       = 2;
  localparam int FIFO_DEPTH      = 4;    // power of two, at least 2

  localparam logic [7:0] WIDE_PAD = 8'h00;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

  // hit kinds
  localparam logic HIT_PLAIN = 1'b0;
  localparam logic HIT_WIDE  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              kind;
    logic              last;
  } hit_t;

  typedef struct packed {
    logic plain;
    logic wide;
  } match_t;

endpackage

`default_nettype wire

// ===== hdl/desc_stream_if.sv =====
// Valid/ready channels of the scanner: byte input and hit output.
// Depends on desc_pkg for field widths.
`default_nettype none

interface desc_in_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 data_byte;
  logic [desc_pkg::ADDR_W-1:0] region_base;
  logic                       last_in_region;

  modport source (output valid, output data_byte, output region_base,
                  output last_in_region, input ready);
  modport sink   (input valid, input data_byte, input region_base,
                  input last_in_region, output ready);
endinterface

interface desc_out_if;
  logic                       valid;
  logic                       ready;
  logic [desc_pkg::ADDR_W-1:0] hit_address;
  logic                       hit_kind;
  logic                       last_of_run;

  modport source (output valid, output hit_address, output hit_kind,
                  output last_of_run, input ready);
  modport sink   (input valid, input hit_address, input hit_kind,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hdl/desc_match.sv =====
// Window compare: plain and wide match of the pattern against the byte window.
// Depends on desc_pkg; purely combinational.
`default_nettype none

module desc_match #(
  parameter int MAX_PATTERN = desc_pkg::MAX_PATTERN_DEF,
  localparam int WIN_DEPTH  = 2 * MAX_PATTERN,
  localparam int FILL_W     = $clog2(WIN_DEPTH + 1),
  localparam int LEN_W      = $clog2(MAX_PATTERN + 1)
) (
  input  logic [7:0]                        win [WIN_DEPTH],
  input  logic [FILL_W-1:0]                 fill,
  input  logic [desc_pkg::PAT_BYTES_W-1:0]  pattern,
  input  logic [LEN_W-1:0]                  len,
  input  logic [MAX_PATTERN-1:0]            hist,
  output desc_pkg::match_t                  match
);
  import desc_pkg::*;

  localparam int IDX_W      = $clog2(WIN_DEPTH);
  localparam int HIST_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  always_comb begin
    logic [IDX_W-1:0] p_idx;
    logic [IDX_W-1:0] w_idx_byte;
    logic [IDX_W-1:0] w_idx_pad;
    logic             plain;
    logic             wide;
    plain = (fill >= FILL_W'(len));
    wide  = (fill >= FILL_W'({len, 1'b0}));
    for (int i = 0; i < MAX_PATTERN; i++) begin
      p_idx      = IDX_W'(int'(len) - 1 - i);
      w_idx_byte = IDX_W'(2 * int'(len) - 1 - 2 * i);
      w_idx_pad  = IDX_W'(2 * int'(len) - 2 - 2 * i);
      if (i < int'(len)) begin
        if (win[p_idx] != pattern[8*i +: 8]) plain = 1'b0;
        if (win[w_idx_byte] != pattern[8*i +: 8] || win[w_idx_pad] != WIDE_PAD) begin
          wide = 1'b0;
        end
      end
    end
    // plain hit at the same start offset wins
    if (hist[HIST_IDX_W'(len - LEN_W'(1))]) wide = 1'b0;
    match.plain = plain;
    match.wide  = wide;
  end

endmodule

`default_nettype wire

// ===== hdl/desc_hit_fifo.sv =====
// Small hit queue: takes up to two hits per cycle, hands out one per cycle.
// Depends on desc_pkg and the assertion macro header.
`default_nettype none
`include "dual_encoding_pattern_scanner_defines.svh"

module desc_hit_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_cnt,
  input  desc_pkg::hit_t push_0,
  input  desc_pkg::hit_t push_1,
  output logic           room_2,
  input  logic           pop,
  output logic           head_valid,
  output desc_pkg::hit_t head
);
  import desc_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  hit_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign do_pop     = pop && head_valid;
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rptr_r];
  assign room_2     = (count_r <= CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wptr_nxt  = wptr_r + PTR_W'(push_cnt);
    rptr_nxt  = rptr_r + PTR_W'(do_pop);
    count_nxt = count_r + CNT_W'(push_cnt) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wptr_r] <= push_0;
    if (push_cnt == 2'd2) mem_r[wptr_r + PTR_W'(1)] <= push_1;
  end

  `DESC_ASSERT(a_fifo_bound, clk, rst_n, count_r <= CNT_W'(FIFO_DEPTH), "hit queue overfilled")
  `DESC_ASSERT_NEXT(a_fifo_count, clk, rst_n, 1'b1, count_r == $past(count_nxt), "hit queue count slip")

endmodule

`default_nettype wire

// ===== hdl/dual_encoding_pattern_scanner.sv =====
// Path: an accepted byte is registered in the compare stage; its hits go to the hit queue.
// Throughput: one byte per cycle while the queue has room for two hits; the queue takes
//   two a cycle and drains one, so two-hit bytes hold input to the output rate.
// Reset: synchronous, active low; clears offset, window fill, hit history, queue
//   and sets pattern_length to 1, pattern bytes to zero.
// Depends on desc_pkg, desc_stream_if, desc_match, desc_hit_fifo and the macro header.
`default_nettype none
`include "dual_encoding_pattern_scanner_defines.svh"

module dual_encoding_pattern_scanner #(
  parameter int MAX_PATTERN = desc_pkg::MAX_PATTERN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  desc_in_if.sink                        in_ch,
  desc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [desc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [desc_pkg::REG_W-1:0]     cfg_data
);
  import desc_pkg::*;

  localparam int WIN_DEPTH = 2 * MAX_PATTERN;
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int LEN_W     = $clog2(MAX_PATTERN + 1);

  // configuration
  logic [REG_W-1:0]     pat_low_r;
  logic [REG_W-1:0]     pat_high_r;
  logic [PAT_LEN_W-1:0] pat_len_r;
  logic [LEN_W-1:0]     len;          // length clamped to 1..MAX_PATTERN

  // region state, advanced at each accepted word (history: as the word leaves compare)
  logic [7:0]           win_r [WIN_DEPTH];  // entry 0 is the newest byte
  logic [FILL_W-1:0]    fill_r, fill_nxt, fill_inc;
  logic [OFF_W-1:0]     off_r, off_nxt;
  logic [MAX_PATTERN-1:0] hist_r, hist_nxt;  // bit j: plain hit ended j+1 words ago

  // compare stage snapshot
  logic                 s1_valid_r, s1_valid_nxt;
  logic [ADDR_W-1:0]    s1_base_r;
  logic [OFF_W-1:0]     s1_off_r;
  logic [FILL_W-1:0]    s1_fill_r;
  logic                 s1_last_r;
  logic                 s1_adv;

  logic                 in_acc;
  logic                 room_2;
  match_t               match;
  hit_t                 hit_plain, hit_wide, push_0, push_1;
  logic [1:0]           push_cnt;
  logic [OFF_W-1:0]     start_plain, start_wide;
  logic                 out_pop;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= PAT_LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAT_LOW:  pat_low_r  <= cfg_data;
        CFG_PAT_HIGH: pat_high_r <= cfg_data;
        CFG_PAT_LEN:  pat_len_r  <= cfg_data[PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pat_len_r == '0) begin
      len = LEN_W'(1);
    end else if (pat_len_r > PAT_LEN_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = pat_len_r[LEN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // input side: a word enters when the compare stage is empty or moving on
  // ---------------------------------------------------------------------------
  assign s1_adv      = s1_valid_r && room_2;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    fill_inc     = (fill_r == FILL_W'(WIN_DEPTH)) ? fill_r : fill_r + FILL_W'(1);
    fill_nxt     = fill_r;
    off_nxt      = off_r;
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) s1_valid_nxt = 1'b0;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
      // region end: next word starts a fresh window at offset zero
      fill_nxt = in_ch.last_in_region ? '0 : fill_inc;
      off_nxt  = in_ch.last_in_region ? '0 : off_r + OFF_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      off_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      off_r      <= off_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // window shift and stage payload, no reset needed (guarded by fill)
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_r[0] <= in_ch.data_byte;
      for (int i = 1; i < WIN_DEPTH; i++) win_r[i] <= win_r[i-1];
      s1_base_r <= in_ch.region_base;
      s1_off_r  <= off_r;
      s1_fill_r <= fill_inc;
      s1_last_r <= in_ch.last_in_region;
    end
  end

  // ---------------------------------------------------------------------------
  // compare stage
  // ---------------------------------------------------------------------------
  desc_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .win     (win_r),
    .fill    (s1_fill_r),
    .pattern ({pat_high_r, pat_low_r}),
    .len     (len),
    .hist    (hist_r),
    .match   (match)
  );

  // history moves only when the compared word leaves the stage
  always_comb begin
    hist_nxt = hist_r;
    if (s1_adv) begin
      hist_nxt = s1_last_r ? '0 : ((hist_r << 1) | MAX_PATTERN'(match.plain));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else begin
      hist_r <= hist_nxt;
    end
  end

  // start offsets wrap at 2^32 before the base is added
  assign start_plain = s1_off_r - (OFF_W'(len) - OFF_W'(1));
  assign start_wide  = s1_off_r - (OFF_W'({len, 1'b0}) - OFF_W'(1));

  always_comb begin
    hit_plain.address = s1_base_r + ADDR_W'(start_plain);
    hit_plain.kind    = HIT_PLAIN;
    hit_plain.last    = 1'b1;
    hit_wide.address  = s1_base_r + ADDR_W'(start_wide);
    hit_wide.kind     = HIT_WIDE;
    hit_wide.last     = !match.plain;
    // wide window starts lower, so it goes out first
    push_0   = match.wide ? hit_wide : hit_plain;
    push_1   = hit_plain;
    push_cnt = 2'd0;
    if (s1_adv) push_cnt = 2'(match.wide) + 2'(match.plain);
  end

  // ---------------------------------------------------------------------------
  // output queue
  // ---------------------------------------------------------------------------
  assign out_pop = out_ch.valid && out_ch.ready;

  desc_hit_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push_0     (push_0),
    .push_1     (push_1),
    .room_2     (room_2),
    .pop        (out_pop),
    .head_valid (out_ch.valid),
    .head       ({out_ch.hit_address, out_ch.hit_kind, out_ch.last_of_run})
  );

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `DESC_ASSERT(a_fill_bound, clk, rst_n, fill_r <= FILL_W'(WIN_DEPTH), "window fill past depth")
  `DESC_ASSERT_NEXT(a_region_clear, clk, rst_n, in_acc && in_ch.last_in_region,
    off_r == '0 && fill_r == '0, "region state not cleared at region end")
  `DESC_ASSERT_NEXT(a_stall_hold, clk, rst_n, s1_valid_r && !s1_adv,
    s1_valid_r && $stable(s1_off_r) && $stable(hist_r), "compare stage lost a stalled word")

endmodule

`default_nettype wire

// ===== test/dual_encoding_pattern_scanner_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for dual_encoding_pattern_scanner: directed table, then random regions.
// Depends on desc_pkg and the desc_in_if / desc_out_if channels of the RTL.

module dual_encoding_pattern_scanner_tb;
  import desc_pkg::*;

  localparam int WIN_DEPTH   = 32;
  localparam int QUIET_LIMIT = 3000;  // cycles with no word moving on either channel
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off used to back the block up
  localparam int SETTLE      = 6;     // margin for words still in the compare stage or hit queue

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  desc_in_if  in_bus ();
  desc_out_if out_bus ();

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  dual_encoding_pattern_scanner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Scanner mirror: configuration copy and window state, updated per accepted word
  // ---------------------------------------------------------------------------
  logic [63:0] pat_lo  = '0;
  logic [63:0] pat_hi  = '0;
  logic [4:0]  pat_len = 5'd1;

  logic [7:0]  win [WIN_DEPTH];
  logic [15:0] plain_hist = '0;   // bit j: a plain hit ended j+1 words ago
  logic [31:0] region_off = '0;
  int          fill = 0;

  hit_t hits_due [$];             // hits the block still owes, oldest first
  int   mismatches = 0;
  int   quiet_cycles = 0;

  // idle percentages for each side; hold request for the receiver
  int src_idle_pct  = 11;
  int sink_idle_pct = 58;
  bit hold_pending  = 1'b0;
  int hold_left     = 0;

  // typed expectation that rides along with the word on the input channel
  logic cur_typed;
  int   cur_n;
  hit_t cur_h0, cur_h1;

  // region carried over a phase boundary (length may change inside it)
  bit          region_open = 1'b0;
  logic [63:0] open_base   = '0;

  initial foreach (win[i]) win[i] = 8'h00;

  function automatic hit_t mk_hit(logic [63:0] addr, logic kind, logic last);
    hit_t h;
    h.address = addr;
    h.kind    = kind;
    h.last    = last;
    return h;
  endfunction

  // length 0 acts as 1, anything above the maximum as the maximum
  function automatic int used_len();
    if (pat_len == 5'd0) return 1;
    if (int'(pat_len) > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
    return int'(pat_len);
  endfunction

  function automatic logic [7:0] pat_byte(int k);
    return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
  endfunction

  // Shift one word into the window and work out the hits it ends.
  // Wide hit (lower start address) comes before the plain hit.
  function automatic int scan_byte(input logic [7:0] b, input logic [63:0] base,
                                   input logic last, output hit_t h0, output hit_t h1);
    int          len;
    int          n;
    bit          plain;
    bit          wide;
    logic [31:0] start;
    hit_t        found [2];

    len = used_len();
    n   = 0;
    for (int i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = b;
    if (fill < WIN_DEPTH) fill++;

    plain = 1'b0;
    if (fill >= len) begin
      plain = 1'b1;
      for (int i = 0; i < len; i++)
        if (win[len-1-i] != pat_byte(i)) plain = 1'b0;
    end

    wide = 1'b0;
    if (fill >= 2 * len) begin
      wide = 1'b1;
      for (int i = 0; i < len; i++)
        if (win[2*len-1-2*i] != pat_byte(i) || win[2*len-2-2*i] != WIDE_PAD) wide = 1'b0;
      // plain hit at the same start wins; history is read with the current length
      if (wide && plain_hist[len-1]) wide = 1'b0;
    end

    found[0] = '0;
    found[1] = '0;
    if (wide) begin
      start = region_off - 32'(2 * len - 1);
      found[n] = mk_hit(base + {32'b0, start}, HIT_WIDE, 1'b0);
      n++;
    end
    if (plain) begin
      start = region_off - 32'(len - 1);
      found[n] = mk_hit(base + {32'b0, start}, HIT_PLAIN, 1'b0);
      n++;
    end
    if (n > 0) found[n-1].last = 1'b1;

    plain_hist = {plain_hist[14:0], plain};
    region_off = region_off + 32'd1;
    if (last) begin
      region_off = '0;
      fill       = 0;
      plain_hist = '0;
    end
    h0 = found[0];
    h1 = found[1];
    return n;
  endfunction

  task automatic flag_hit(string why, hit_t want, hit_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected addr=%h kind=%0d last=%0d, got addr=%h kind=%0d last=%0d",
               why, want.address, want.kind, want.last, got.address, got.kind, got.last);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check hits leaving, predict hits for words entering, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    hit_t got, want, h0, h1;
    int   n;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got = mk_hit(out_bus.hit_address, out_bus.hit_kind, out_bus.last_of_run);
        if (hits_due.size() == 0) begin
          flag_hit("no hit expected", '0, got);
        end else begin
          want = hits_due.pop_front();
          if (got.address !== want.address || got.kind !== want.kind ||
              got.last !== want.last)
            flag_hit("field", want, got);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        n = scan_byte(in_bus.data_byte, in_bus.region_base, in_bus.last_in_region, h0, h1);
        // directed rows with a hand-written answer replace the mirror's answer
        if (cur_typed) begin
          n  = cur_n;
          h0 = cur_h0;
          h1 = cur_h1;
        end
        if (n > 0) hits_due.push_back(h0);
        if (n > 1) hits_due.push_back(h1);
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off counted down here
  always @(posedge clk) begin
    if (hold_pending) begin
      hold_left    = HOLD_CYCLES;
      hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------
  // Offer one word and return at the edge that takes it; valid stays up after.
  // Each cycle before the word idles with the sender's idle percentage.
  task automatic send_byte(logic [7:0] b, logic [63:0] base, logic last,
                           logic typed, int n, hit_t h0, hit_t h1);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.data_byte      <= b;
    in_bus.region_base    <= base;
    in_bus.last_in_region <= last;
    cur_typed <= typed;
    cur_n     <= n;
    cur_h0    <= h0;
    cur_h1    <= h1;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Stop sending, let every owed hit drain, then cover words still in flight.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (hits_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Leaves cfg_we high so back-to-back writes need no toggle; caller lowers it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_PAT_LOW:  pat_lo  = val;
      CFG_PAT_HIGH: pat_hi  = val;
      CFG_PAT_LEN:  pat_len = val[4:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [63:0] value;   // register data, or region base for a word
    logic [7:0]  b;
    logic        last;
    logic        typed;
    int          n;
    hit_t        h0;
    hit_t        h1;
  } stim_row_t;

  stim_row_t dir_rows [$];

  function automatic stim_row_t cfg_row(logic [1:0] idx, logic [63:0] val);
    stim_row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = val;
    return r;
  endfunction

  function automatic stim_row_t byte_row(logic [7:0] b, logic [63:0] base, logic last,
                                         logic typed, int n, hit_t h0, hit_t h1);
    stim_row_t r;
    r       = '{default: '0};
    r.b     = b;
    r.value = base;
    r.last  = last;
    r.typed = typed;
    r.n     = n;
    r.h0    = h0;
    r.h1    = h1;
    return r;
  endfunction

  task automatic build_table();
    // reset state: pattern 00, length 1
    dir_rows.push_back(byte_row(8'h00, 64'h1000, 1'b0, 1'b1, 1,
                                mk_hit(64'h1000, HIT_PLAIN, 1'b1), '0));
    // wide window 00 00 also matches, but the plain hit at its start wins
    dir_rows.push_back(byte_row(8'h00, 64'h1000, 1'b1, 1'b1, 1,
                                mk_hit(64'h1001, HIT_PLAIN, 1'b1), '0));
    dir_rows.push_back(byte_row(8'hFF, '1, 1'b1, 1'b1, 0, '0, '0));
    // all-ones pattern, length 2; address wraps past 2^64
    dir_rows.push_back(cfg_row(CFG_PAT_LOW, '1));
    dir_rows.push_back(cfg_row(CFG_PAT_LEN, 64'd2));
    dir_rows.push_back(byte_row(8'hFF, '1, 1'b0, 1'b1, 0, '0, '0));
    dir_rows.push_back(byte_row(8'hFF, '1, 1'b0, 1'b1, 1, mk_hit('1, HIT_PLAIN, 1'b1), '0));
    dir_rows.push_back(byte_row(8'hFF, '1, 1'b1, 1'b1, 1, mk_hit('0, HIT_PLAIN, 1'b1), '0));
    // pattern "AB": wide form 41 00 42 00, then plain form
    dir_rows.push_back(cfg_row(CFG_PAT_LOW, 64'h4241));
    dir_rows.push_back(cfg_row(CFG_PAT_HIGH, '1));
    dir_rows.push_back(cfg_row(CFG_PAT_LEN, 64'd2));
    dir_rows.push_back(byte_row(8'h41, 64'h2000, 1'b0, 1'b1, 0, '0, '0));
    dir_rows.push_back(byte_row(8'h00, 64'h2000, 1'b0, 1'b1, 0, '0, '0));
    dir_rows.push_back(byte_row(8'h42, 64'h2000, 1'b0, 1'b1, 0, '0, '0));
    dir_rows.push_back(byte_row(8'h00, 64'h2000, 1'b0, 1'b1, 1,
                                mk_hit(64'h2000, HIT_WIDE, 1'b1), '0));
    dir_rows.push_back(byte_row(8'h41, 64'h2000, 1'b0, 1'b1, 0, '0, '0));
    dir_rows.push_back(byte_row(8'h42, 64'h2000, 1'b1, 1'b1, 1,
                                mk_hit(64'h2004, HIT_PLAIN, 1'b1), '0));
    // pattern 00 01, then shrink to length 0 (acts as 1) inside the same region:
    // one word ends a wide and a plain hit
    dir_rows.push_back(cfg_row(CFG_PAT_LOW, 64'h0100));
    dir_rows.push_back(byte_row(8'h00, 64'h3000, 1'b0, 1'b1, 0, '0, '0));
    dir_rows.push_back(byte_row(8'h00, 64'h3000, 1'b0, 1'b1, 0, '0, '0));
    dir_rows.push_back(cfg_row(CFG_PAT_LOW, 64'h0));
    dir_rows.push_back(cfg_row(CFG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFE0));
    dir_rows.push_back(byte_row(8'h00, 64'h3000, 1'b1, 1'b1, 2,
                                mk_hit(64'h3001, HIT_WIDE, 1'b0),
                                mk_hit(64'h3002, HIT_PLAIN, 1'b1)));
    // length code above the maximum
    dir_rows.push_back(cfg_row(CFG_PAT_LEN, 64'h1F));
  endtask

  task automatic run_table();
    bit in_cfg;
    in_cfg = 1'b0;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        if (!in_cfg) wait_idle();
        write_reg(dir_rows[r].idx, dir_rows[r].value);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) cfg_we <= 1'b0;
        in_cfg = 1'b0;
        send_byte(dir_rows[r].b, dir_rows[r].value, dir_rows[r].last, dir_rows[r].typed,
                  dir_rows[r].n, dir_rows[r].h0, dir_rows[r].h1);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_pat_byte(int flavor);
    case (flavor)
      0: return 8'($urandom);
      1: return ($urandom_range(1) != 0) ? 8'h41 : 8'h00;   // tiny alphabet, overlaps
      2: return 8'h00;
      3: return 8'hFF;
      default: return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_base();
    case ($urandom_range(3))
      0: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(60));  // wraps
      1: return 64'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // New pattern and length, then regions built mostly from pattern copies.
  task automatic random_phase(int n_items);
    logic [63:0] lo, hi, len_word;
    logic [4:0]  code;
    int          flavor, plen, rlen, sent, brk, r;
    bit          keep_open;
    logic [63:0] base;
    logic [7:0]  seg [$];

    flavor = $urandom_range(4);
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = pick_pat_byte(flavor);
      hi[8*k +: 8] = pick_pat_byte(flavor);
    end
    r = $urandom_range(99);
    if (r < 55)      code = 5'($urandom_range(1, 4));
    else if (r < 82) code = 5'($urandom_range(5, 16));
    else if (r < 91) code = 5'd0;
    else             code = 5'($urandom_range(17, 31));
    len_word = {$urandom, $urandom};
    len_word[4:0] = code;

    wait_idle();
    write_reg(CFG_PAT_LOW, lo);
    write_reg(CFG_PAT_HIGH, hi);
    write_reg(CFG_PAT_LEN, len_word);
    cfg_we <= 1'b0;
    plen = used_len();

    sent = 0;
    while (sent < n_items) begin
      base = region_open ? open_base : pick_base();
      rlen = ($urandom_range(9) == 0) ? $urandom_range(41, 96) : $urandom_range(1, 40);
      // the phase ends on its word budget
      if (rlen > n_items - sent) rlen = n_items - sent;
      seg.delete();
      while (seg.size() < rlen) begin
        case ($urandom_range(9))
          0, 1, 2: for (int k = 0; k < plen; k++) seg.push_back(pat_byte(k));
          3, 4, 5:
            for (int k = 0; k < plen; k++) begin
              seg.push_back(pat_byte(k));
              seg.push_back(WIDE_PAD);
            end
          6: begin
            // pattern with one bit flipped somewhere
            brk = $urandom_range(plen - 1);
            for (int k = 0; k < plen; k++)
              seg.push_back((k == brk) ? pat_byte(k) ^ 8'(1 << $urandom_range(7))
                                       : pat_byte(k));
          end
          7: repeat ($urandom_range(1, 4)) seg.push_back(WIDE_PAD);
          default: repeat ($urandom_range(1, 3)) seg.push_back(8'($urandom));
        endcase
      end
      // the phase's last region may stay open so the next setting applies mid-region
      keep_open = (sent + rlen >= n_items) && ($urandom_range(2) == 0);
      for (int k = 0; k < rlen; k++)
        send_byte(seg[k], base, (k == rlen - 1) && !keep_open, 1'b0, 0, '0, '0);
      sent += rlen;
      region_open = keep_open;
      open_base   = base;
    end
  endtask

  // Receiver holds off for a long stretch while words keep coming, so the hit
  // queue fills and the input stalls; then the sender waits for the drain.
  task automatic stall_burst();
    logic [63:0] base;
    wait_idle();
    write_reg(CFG_PAT_LOW, 64'hAB);
    write_reg(CFG_PAT_LEN, 64'd1);
    cfg_we <= 1'b0;
    base = region_open ? open_base : 64'hABAB_0000_0000_0000;
    hold_pending = 1'b1;
    for (int k = 0; k < 48; k++)
      send_byte(8'hAB, base, k == 47, 1'b0, 0, '0, '0);
    region_open = 1'b0;
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int done, n;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    in_bus.valid          = 1'b0;
    in_bus.data_byte      = '0;
    in_bus.region_base    = '0;
    in_bus.last_in_region = 1'b0;
    out_bus.ready         = 1'b0;
    cur_typed             = 1'b0;
    cur_n                 = 0;
    cur_h0                = '0;
    cur_h1                = '0;

    build_table();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_table();

    // three idle mixes: sender light / receiver heavy, swapped, then none
    for (int m = 0; m < 3; m++) begin
      src_idle_pct  = (m == 0) ? 11 : (m == 1) ? 58 : 0;
      sink_idle_pct = (m == 0) ? 58 : (m == 1) ? 11 : 0;
      if (m == 2) stall_burst();
      done = 0;
      while (done < 500) begin
        n = $urandom_range(30, 90);
        random_phase(n);
        done += n;
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && hits_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
